>>> hdl/kma_pkg.sv
// Shared widths, codes and defaults for the k-means assignment block.
`default_nettype none
package kma_pkg;
    localparam int COORD_WIDTH      = 16;
    localparam int CFG_WIDTH        = 5;
    localparam int SUM_WIDTH        = 40;
    localparam int PART_WIDTH       = 38;
    localparam int DIST_WIDTH       = 36;
    localparam int COUNT_WIDTH      = 24;
    localparam int CLUSTER_WIDTH    = 4;
    localparam int DIM_WIDTH        = 4;
    localparam int SQ_WIDTH         = 2 * COORD_WIDTH + 1;
    localparam int MAX_CLUSTERS_DEF = 16;
    localparam int MAX_DIMS_DEF     = 16;
    localparam logic [CFG_WIDTH-1:0] CFG_RESET = CFG_WIDTH'(2);

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_POINT = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic {
        REG_NUM_CLUSTERS = 1'b0,
        REG_NUM_DIMS     = 1'b1
    } t_reg_idx;

    typedef enum logic {
        KIND_ASSIGN  = 1'b0,
        KIND_READOUT = 1'b1
    } t_kind;
endpackage
`default_nettype wire

>>> hdl/kmeans_assign_accumulate.sv
// Top level: k-means assignment with per-cluster sum and count accumulation.
`default_nettype none
// One transaction is handled at a time. A point coordinate walks the clusters
// through the centroid and partial-distance memories with a single
// squared-difference unit; the last coordinate of a point then does the sum
// and count read-modify-write. A clear, and the pass after reset, sweeps all
// MAX_CLUSTERS*MAX_DIMS sum entries and the count entries with input held off.
// A finished result sits in an output register while the next input is taken;
// a further result waits in the output state until it is free.
module kmeans_assign_accumulate import kma_pkg::*; #(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
    parameter int MAX_DIMS     = MAX_DIMS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [CFG_WIDTH-1:0]          i_cfg_value,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_command,
    input  wire logic [CLUSTER_WIDTH-1:0]      i_cluster_index,
    input  wire logic [DIM_WIDTH-1:0]          i_dim_index,
    input  wire logic signed [COORD_WIDTH-1:0] i_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_result_kind,
    output logic [CLUSTER_WIDTH-1:0]           o_cluster,
    output logic [DIST_WIDTH-1:0]              o_min_distance,
    output logic signed [SUM_WIDTH-1:0]        o_sum_value,
    output logic [COUNT_WIDTH-1:0]             o_count_value
);
    localparam int DEPTH = MAX_CLUSTERS * MAX_DIMS;
    localparam int CW    = $clog2(MAX_CLUSTERS);
    localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NCW   = $clog2(MAX_CLUSTERS + 1);
    localparam int NDW   = $clog2(MAX_DIMS + 1);

    typedef enum logic [3:0] {
        ST_SWEEP, ST_IDLE, ST_DECODE, ST_R_WAIT, ST_D_RD, ST_D_MUL, ST_D_ACC,
        ST_S_RD, ST_S_WR, ST_C_RD, ST_C_WR, ST_OUT
    } t_state;

    t_state r_state;
    logic [CFG_WIDTH-1:0]          r_num_clusters, r_num_dims;
    t_cmd                          r_cmd;
    logic [CLUSTER_WIDTH-1:0]      r_c;
    logic [DIM_WIDTH-1:0]          r_d;
    logic signed [COORD_WIDTH-1:0] r_v;
    logic [NCW-1:0]                r_k;
    logic [NDW-1:0]                r_l;
    logic [AW-1:0]                 r_idx;
    logic                          r_last;
    logic [CW-1:0]                 r_best;
    logic [PART_WIDTH-1:0]         r_best_d;
    logic [SQ_WIDTH-2:0]           r_sq;
    logic [PART_WIDTH-1:0]         r_base;
    logic [MAX_CLUSTERS-1:0]       r_pd_valid;
    logic                          r_p_kind;
    logic [CLUSTER_WIDTH-1:0]      r_p_cluster;
    logic [DIST_WIDTH-1:0]         r_p_dist;
    logic signed [SUM_WIDTH-1:0]   r_p_sum;
    logic [COUNT_WIDTH-1:0]        r_p_count;

    logic [NCW-1:0] w_nc;
    logic [NDW-1:0] w_nd;
    logic           w_in_range;

    // centroid, sums, counts, point buffer and partial distance memories
    logic                   w_cen_we, w_sum_we, w_cnt_we, w_pb_we, w_pd_we;
    logic [AW-1:0]          w_cen_waddr, w_cen_raddr, w_sum_waddr, w_sum_raddr;
    logic [SUM_WIDTH-1:0]   w_sum_wdata, w_sum_rdata;
    logic [CW-1:0]          w_cnt_waddr, w_cnt_raddr, w_pd_waddr, w_pd_raddr;
    logic [COUNT_WIDTH-1:0] w_cnt_wdata, w_cnt_rdata;
    logic [DW-1:0]          w_pb_waddr, w_pb_raddr;
    logic [COORD_WIDTH-1:0] w_cen_rdata, w_pb_rdata;
    logic [PART_WIDTH-1:0]  w_pd_wdata, w_pd_rdata;

    logic signed [COORD_WIDTH:0]     w_diff;
    logic signed [2*COORD_WIDTH+1:0] w_prod;
    logic [PART_WIDTH:0]             w_acc;
    logic signed [SUM_WIDTH:0]       w_sum_ext;

    function automatic logic [AW-1:0] flat(int c, int d);
        return AW'(c * MAX_DIMS + d);
    endfunction

    always_comb begin
        if (r_num_clusters == '0) begin
            w_nc = NCW'(1);
        end else if (int'(r_num_clusters) > MAX_CLUSTERS) begin
            w_nc = NCW'(MAX_CLUSTERS);
        end else begin
            w_nc = NCW'(r_num_clusters);
        end
        if (r_num_dims == '0) begin
            w_nd = NDW'(1);
        end else if (int'(r_num_dims) > MAX_DIMS) begin
            w_nd = NDW'(MAX_DIMS);
        end else begin
            w_nd = NDW'(r_num_dims);
        end
    end

    assign w_in_range = (int'(r_c) < MAX_CLUSTERS) && (int'(r_d) < MAX_DIMS);

    assign w_diff = $signed({r_v[COORD_WIDTH-1], r_v})
                  - $signed({w_cen_rdata[COORD_WIDTH-1], w_cen_rdata});
    assign w_prod = w_diff * w_diff;
    assign w_acc  = {1'b0, r_base} + (PART_WIDTH + 1)'(r_sq);
    assign w_sum_ext = $signed({w_sum_rdata[SUM_WIDTH-1], w_sum_rdata})
                     + (SUM_WIDTH + 1)'($signed(w_pb_rdata));

    always_comb begin
        w_cen_we    = (r_state == ST_DECODE) && (r_cmd == CMD_LOAD) && w_in_range;
        w_cen_waddr = flat(int'(r_c), int'(r_d));
        w_cen_raddr = flat(int'(r_k[CW-1:0]), int'(r_d));
        w_pb_we     = (r_state == ST_DECODE) && (r_cmd == CMD_POINT)
                    && (int'(r_d) < int'(w_nd));
        w_pb_waddr  = DW'(r_d);
        w_pb_raddr  = DW'(r_l);
        w_pd_we     = (r_state == ST_D_ACC);
        w_pd_waddr  = r_k[CW-1:0];
        w_pd_raddr  = r_k[CW-1:0];
        w_pd_wdata  = w_acc[PART_WIDTH] ? '1 : w_acc[PART_WIDTH-1:0];

        w_sum_we    = 1'b0;
        w_sum_waddr = flat(int'(r_best), int'(r_l));
        w_sum_wdata = '0;
        w_sum_raddr = flat(int'(r_best), int'(r_l));
        w_cnt_we    = 1'b0;
        w_cnt_waddr = r_best;
        w_cnt_wdata = '0;
        w_cnt_raddr = r_best;
        case (r_state)
            ST_SWEEP: begin
                w_sum_we    = 1'b1;
                w_sum_waddr = r_idx;
                w_cnt_we    = (int'(r_idx) < MAX_CLUSTERS);
                w_cnt_waddr = CW'(r_idx);
            end
            ST_DECODE: begin
                w_sum_raddr = flat(int'(r_c), int'(r_d));
                w_cnt_raddr = CW'(r_c);
            end
            ST_S_WR: begin
                w_sum_we = 1'b1;
                // saturate to the signed sum range
                if (w_sum_ext[SUM_WIDTH] != w_sum_ext[SUM_WIDTH-1]) begin
                    w_sum_wdata = {w_sum_ext[SUM_WIDTH], {(SUM_WIDTH-1){~w_sum_ext[SUM_WIDTH]}}};
                end else begin
                    w_sum_wdata = w_sum_ext[SUM_WIDTH-1:0];
                end
            end
            ST_C_WR: begin
                w_cnt_we    = 1'b1;
                w_cnt_wdata = (&w_cnt_rdata) ? w_cnt_rdata : w_cnt_rdata + 1'b1;
            end
            default: begin
            end
        endcase
    end

    kma_ram #(.WIDTH(COORD_WIDTH), .DEPTH(DEPTH)) u_centroid (
        .i_clk(i_clk), .i_we(w_cen_we), .i_waddr(w_cen_waddr), .i_wdata(r_v),
        .i_raddr(w_cen_raddr), .o_rdata(w_cen_rdata)
    );
    kma_ram #(.WIDTH(SUM_WIDTH), .DEPTH(DEPTH)) u_sums (
        .i_clk(i_clk), .i_we(w_sum_we), .i_waddr(w_sum_waddr), .i_wdata(w_sum_wdata),
        .i_raddr(w_sum_raddr), .o_rdata(w_sum_rdata)
    );
    kma_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_CLUSTERS)) u_counts (
        .i_clk(i_clk), .i_we(w_cnt_we), .i_waddr(w_cnt_waddr), .i_wdata(w_cnt_wdata),
        .i_raddr(w_cnt_raddr), .o_rdata(w_cnt_rdata)
    );
    kma_ram #(.WIDTH(COORD_WIDTH), .DEPTH(MAX_DIMS)) u_point (
        .i_clk(i_clk), .i_we(w_pb_we), .i_waddr(w_pb_waddr), .i_wdata(r_v),
        .i_raddr(w_pb_raddr), .o_rdata(w_pb_rdata)
    );
    kma_ram #(.WIDTH(PART_WIDTH), .DEPTH(MAX_CLUSTERS)) u_partial (
        .i_clk(i_clk), .i_we(w_pd_we), .i_waddr(w_pd_waddr), .i_wdata(w_pd_wdata),
        .i_raddr(w_pd_raddr), .o_rdata(w_pd_rdata)
    );

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_SWEEP;
            r_idx          <= '0;
            r_num_clusters <= CFG_RESET;
            r_num_dims     <= CFG_RESET;
            r_pd_valid     <= '0;
            o_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (t_reg_idx'(i_cfg_index) == REG_NUM_CLUSTERS) begin
                    r_num_clusters <= i_cfg_value;
                end else begin
                    r_num_dims <= i_cfg_value;
                end
            end
            if (r_state == ST_OUT && (!o_out_valid || i_out_ready)) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                ST_SWEEP: begin
                    r_idx <= r_idx + 1'b1;
                    if (int'(r_idx) == DEPTH - 1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= t_cmd'(i_command);
                        r_c     <= i_cluster_index;
                        r_d     <= i_dim_index;
                        r_v     <= i_value;
                        r_state <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    r_k <= '0;
                    r_l <= '0;
                    case (r_cmd)
                        CMD_CLEAR: begin
                            r_idx   <= '0;
                            r_state <= ST_SWEEP;
                        end
                        CMD_READ: begin
                            r_state <= ST_R_WAIT;
                        end
                        CMD_POINT: begin
                            r_last  <= (int'(r_d) == int'(w_nd) - 1);
                            r_state <= (int'(r_d) < int'(w_nd)) ? ST_D_RD : ST_IDLE;
                        end
                        default: begin
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
                ST_R_WAIT: begin
                    r_p_kind    <= KIND_READOUT;
                    r_p_cluster <= r_c;
                    r_p_dist    <= '0;
                    r_p_sum     <= w_in_range ? w_sum_rdata : '0;
                    r_p_count   <= w_in_range ? w_cnt_rdata : '0;
                    r_state     <= ST_OUT;
                end
                ST_D_RD: begin
                    r_state <= ST_D_MUL;
                end
                ST_D_MUL: begin
                    r_sq    <= w_prod[SQ_WIDTH-2:0];
                    r_base  <= (r_d == '0 || !r_pd_valid[r_k[CW-1:0]]) ? '0 : w_pd_rdata;
                    r_state <= ST_D_ACC;
                end
                ST_D_ACC: begin
                    r_pd_valid[r_k[CW-1:0]] <= 1'b1;
                    // strict less-than keeps the lowest index on ties
                    if (r_k == '0 || w_pd_wdata < r_best_d) begin
                        r_best   <= r_k[CW-1:0];
                        r_best_d <= w_pd_wdata;
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k + 1'b1 == w_nc) begin
                        r_state <= r_last ? ST_S_RD : ST_IDLE;
                    end else begin
                        r_state <= ST_D_RD;
                    end
                end
                ST_S_RD: begin
                    r_state <= ST_S_WR;
                end
                ST_S_WR: begin
                    r_l <= r_l + 1'b1;
                    r_state <= (r_l + 1'b1 == w_nd) ? ST_C_RD : ST_S_RD;
                end
                ST_C_RD: begin
                    r_state <= ST_C_WR;
                end
                ST_C_WR: begin
                    r_pd_valid    <= '0;
                    r_p_kind      <= KIND_ASSIGN;
                    r_p_cluster   <= CLUSTER_WIDTH'(r_best);
                    r_p_dist      <= (|r_best_d[PART_WIDTH-1:DIST_WIDTH]) ? '1
                                   : r_best_d[DIST_WIDTH-1:0];
                    r_p_sum       <= '0;
                    r_p_count     <= '0;
                    r_state       <= ST_OUT;
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (!o_out_valid || i_out_ready) begin
                        o_result_kind  <= r_p_kind;
                        o_cluster      <= r_p_cluster;
                        o_min_distance <= r_p_dist;
                        o_sum_value    <= r_p_sum;
                        o_count_value  <= r_p_count;
                        r_state        <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_DECODE))
        else $error("accepted transaction not decoded");
    a_out_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result raised outside the output state");
    a_cluster_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_D_RD) |-> (r_k < w_nc))
        else $error("cluster counter beyond active clusters");
    a_assign_zero_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_ASSIGN)
            |-> (o_sum_value == '0 && o_count_value == '0))
        else $error("assignment carries accumulator data");
`endif
endmodule
`default_nettype wire

>>> hdl/kma_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none
module kma_ram import kma_pkg::*; #(
    parameter int WIDTH = COORD_WIDTH,
    parameter int DEPTH = MAX_DIMS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
